// ===== hw/rtl/lrucp_pkg.sv =====
// shared constants and types for the lru cache core
package lrucp_pkg;

   localparam int ENTRIES    = 16;
   localparam int SLOT_W     = $clog2(ENTRIES);
   localparam int KEY_BITS   = 64;
   localparam int KEY_W      = 64;
   localparam int HASH_W     = 32;
   localparam int VALUE_W    = 64;
   localparam int CHARGE_W   = 32;
   localparam int HANDLE_W   = 4;
   localparam int TYPE_W     = 3;
   localparam int STATUS_W   = 3;
   localparam int REF_W      = 8;
   localparam int STAMP_W    = 32;
   localparam int CAP_W      = 36;
   localparam int USAGE_W    = 37;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [REF_W-1:0] REF_MAX = '1;

   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY = 4'h0;

   localparam logic [TYPE_W-1:0] REQ_INSERT  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_LOOKUP  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_RELEASE = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_ERASE   = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_PRUNE   = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_SLOT = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_REF_LIM = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_BAD_HDL = 3'd4;

   localparam logic KIND_RESP   = 1'b0;
   localparam logic KIND_NOTICE = 1'b1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LATCH,
      OP_DECIDE,
      OP_DROP,
      OP_SCAN_INIT,
      OP_SCAN_STEP,
      OP_TAKE_BEST,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic go_drop;
      logic go_evict;
      logic evict_want;
      logic scan_last;
      logic best_valid;
   } dp_status_type;

endpackage

// ===== hw/rtl/lrucp_dp.sv =====
// datapath: entry store, match, victim scan and result staging
module lrucp_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  lrucp_pkg::op_type                 op,
   input  logic [lrucp_pkg::CAP_W-1:0]       capacity,
   input  logic [lrucp_pkg::TYPE_W-1:0]      req_type,
   input  logic [lrucp_pkg::KEY_W-1:0]       req_key,
   input  logic [lrucp_pkg::HASH_W-1:0]      req_key_hash,
   input  logic [lrucp_pkg::VALUE_W-1:0]     req_value,
   input  logic [lrucp_pkg::CHARGE_W-1:0]    req_charge,
   input  logic [lrucp_pkg::HANDLE_W-1:0]    req_handle,
   output lrucp_pkg::dp_status_type          status,
   output logic                              rsp_valid,
   output logic                              rsp_kind,
   output logic [lrucp_pkg::STATUS_W-1:0]    rsp_status,
   output logic [lrucp_pkg::HANDLE_W-1:0]    rsp_slot,
   output logic [lrucp_pkg::KEY_W-1:0]       rsp_out_key,
   output logic [lrucp_pkg::VALUE_W-1:0]     rsp_out_value,
   output logic                              rsp_last
);
   import lrucp_pkg::*;

   logic [TYPE_W-1:0]   rtype_ff;
   logic [KEY_BITS-1:0] rkey_ff;
   logic [HASH_W-1:0]   rhash_ff;
   logic [VALUE_W-1:0]  rval_ff;
   logic [CHARGE_W-1:0] rcharge_ff;
   logic [HANDLE_W-1:0] rhandle_ff;

   logic [ENTRIES-1:0]  used_ff;
   logic [ENTRIES-1:0]  cached_ff;
   logic [REF_W-1:0]    refc_ff   [ENTRIES];
   logic [STAMP_W-1:0]  stamp_ff  [ENTRIES];
   logic [KEY_BITS-1:0] ekey_ff   [ENTRIES];
   logic [HASH_W-1:0]   ehash_ff  [ENTRIES];
   logic [VALUE_W-1:0]  eval_ff   [ENTRIES];
   logic [CHARGE_W-1:0] echarge_ff[ENTRIES];
   logic [STAMP_W-1:0]  rcnt_ff;
   logic [USAGE_W-1:0]  usage_ff;

   logic [SLOT_W-1:0]   sel_ff;
   logic                uncache_ff;
   logic                prune_ff;
   logic [SLOT_W-1:0]   best_ff;
   logic [STAMP_W-1:0]  best_age_ff;
   logic                best_valid_ff;

   logic                hold_valid_ff;
   logic                hold_kind_ff;
   logic [STATUS_W-1:0] hold_status_ff;
   logic [SLOT_W-1:0]   hold_slot_ff;
   logic [KEY_BITS-1:0] hold_key_ff;
   logic [VALUE_W-1:0]  hold_value_ff;

   logic                rsp_valid_ff;
   logic                rsp_kind_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [KEY_BITS-1:0] rsp_key_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic                rsp_last_ff;

   logic [ENTRIES-1:0]  match_vec;
   logic                free_found;
   logic [SLOT_W-1:0]   free_idx;
   logic                match_found;
   logic [SLOT_W-1:0]   match_idx;
   logic                cap_on;
   logic [SLOT_W-1:0]   hsel;
   logic                rel_ok;
   logic                lim_hit;

   logic                prod;
   logic                prod_kind;
   logic [STATUS_W-1:0] prod_status;
   logic [SLOT_W-1:0]   prod_slot;
   logic [KEY_BITS-1:0] prod_key;
   logic [VALUE_W-1:0]  prod_value;

   logic                go_drop;
   logic                go_evict;
   logic                is_insert;
   logic [REF_W-1:0]    dref;
   logic                dfree;
   logic                cand;
   logic [STAMP_W-1:0]  age;
   logic                better;

   always_comb begin
      free_found  = 1'b0;
      free_idx    = '0;
      match_found = 1'b0;
      match_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         match_vec[i] = used_ff[i] && cached_ff[i] && (ekey_ff[i] == rkey_ff)
                        && (ehash_ff[i] == rhash_ff);
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
         if (match_vec[i]) begin
            match_found = 1'b1;
            match_idx   = SLOT_W'(i);
         end
      end
   end

   assign cap_on    = (capacity != '0);
   assign hsel      = rhandle_ff[SLOT_W-1:0];
   assign rel_ok    = (32'(rhandle_ff) < ENTRIES) && used_ff[hsel] && (refc_ff[hsel] != '0)
                      && !(cached_ff[hsel] && (refc_ff[hsel] == REF_W'(1)));
   assign lim_hit   = (refc_ff[match_idx] == REF_MAX);
   assign is_insert = (rtype_ff == REQ_INSERT) && free_found;

   assign dref  = refc_ff[sel_ff] - REF_W'(1);
   assign dfree = (dref == '0);

   assign cand   = used_ff[sel_ff] && cached_ff[sel_ff] && (refc_ff[sel_ff] == REF_W'(1));
   assign age    = rcnt_ff - stamp_ff[sel_ff];
   assign better = cand && (!best_valid_ff || (age > best_age_ff));

   always_comb begin
      prod        = 1'b0;
      prod_kind   = KIND_RESP;
      prod_status = STAT_OK;
      prod_slot   = '0;
      prod_key    = '0;
      prod_value  = '0;
      go_drop     = 1'b0;
      go_evict    = 1'b0;
      if (op == OP_DECIDE) begin
         prod = 1'b1;
         case (rtype_ff)
            REQ_INSERT: begin
               if (free_found) begin
                  prod_slot = free_idx;
                  go_drop   = cap_on && match_found;
                  go_evict  = 1'b1;
               end else begin
                  prod_status = STAT_NO_SLOT;
               end
            end
            REQ_LOOKUP: begin
               if (!match_found) begin
                  prod_status = STAT_MISS;
               end else if (lim_hit) begin
                  prod_status = STAT_REF_LIM;
                  prod_slot   = match_idx;
               end else begin
                  prod_slot  = match_idx;
                  prod_value = eval_ff[match_idx];
               end
            end
            REQ_RELEASE: begin
               if (rel_ok) begin
                  go_drop = 1'b1;
               end else begin
                  prod_status = STAT_BAD_HDL;
               end
            end
            REQ_ERASE: begin
               if (match_found) begin
                  go_drop = 1'b1;
               end else begin
                  prod_status = STAT_MISS;
               end
            end
            REQ_PRUNE: begin
               go_evict = 1'b1;
            end
            default: begin
               prod_status = STAT_MISS;
            end
         endcase
      end else if (op == OP_DROP && dfree) begin
         prod       = 1'b1;
         prod_kind  = KIND_NOTICE;
         prod_slot  = sel_ff;
         prod_key   = ekey_ff[sel_ff];
         prod_value = eval_ff[sel_ff];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (op == OP_LATCH) begin
         rtype_ff   <= req_type;
         rkey_ff    <= req_key[KEY_BITS-1:0];
         rhash_ff   <= req_key_hash;
         rval_ff    <= req_value;
         rcharge_ff <= req_charge;
         rhandle_ff <= req_handle;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (op == OP_DECIDE && is_insert) begin
         ekey_ff[free_idx]    <= rkey_ff;
         ehash_ff[free_idx]   <= rhash_ff;
         eval_ff[free_idx]    <= rval_ff;
         echarge_ff[free_idx] <= rcharge_ff;
      end
   end

   // entry control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         cached_ff <= '0;
         rcnt_ff   <= '0;
         usage_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            refc_ff[i]  <= '0;
            stamp_ff[i] <= '0;
         end
      end else begin
         case (op)
            OP_DECIDE: begin
               if (is_insert) begin
                  used_ff[free_idx]   <= 1'b1;
                  stamp_ff[free_idx]  <= '0;
                  cached_ff[free_idx] <= cap_on;
                  refc_ff[free_idx]   <= cap_on ? REF_W'(2) : REF_W'(1);
                  if (cap_on) begin
                     usage_ff <= usage_ff + USAGE_W'(rcharge_ff);
                  end
               end else if (rtype_ff == REQ_LOOKUP && match_found && !lim_hit) begin
                  refc_ff[match_idx] <= refc_ff[match_idx] + REF_W'(1);
               end
            end
            OP_DROP: begin
               refc_ff[sel_ff] <= dref;
               if (uncache_ff) begin
                  usage_ff <= usage_ff - USAGE_W'(echarge_ff[sel_ff]);
               end
               if (uncache_ff || dfree) begin
                  cached_ff[sel_ff] <= 1'b0;
               end
               if (dfree) begin
                  used_ff[sel_ff] <= 1'b0;
               end else if (!uncache_ff && cached_ff[sel_ff] && dref == REF_W'(1)) begin
                  stamp_ff[sel_ff] <= rcnt_ff;
                  rcnt_ff          <= rcnt_ff + STAMP_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // slot pointer and victim scan
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff        <= '0;
         uncache_ff    <= 1'b0;
         prune_ff      <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         case (op)
            OP_DECIDE: begin
               prune_ff   <= (rtype_ff == REQ_PRUNE);
               uncache_ff <= (rtype_ff != REQ_RELEASE);
               sel_ff     <= (rtype_ff == REQ_RELEASE) ? hsel : match_idx;
            end
            OP_SCAN_INIT: begin
               sel_ff        <= '0;
               best_valid_ff <= 1'b0;
            end
            OP_SCAN_STEP: begin
               sel_ff <= sel_ff + SLOT_W'(1);
               if (better) begin
                  best_valid_ff <= 1'b1;
                  best_ff       <= sel_ff;
                  best_age_ff   <= age;
               end
            end
            OP_TAKE_BEST: begin
               sel_ff     <= best_ff;
               uncache_ff <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // one-deep holding stage so the final result can carry last
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= (prod || op == OP_FINISH) && hold_valid_ff;
         if (prod) begin
            hold_valid_ff <= 1'b1;
         end else if (op == OP_FINISH) begin
            hold_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod) begin
         hold_kind_ff   <= prod_kind;
         hold_status_ff <= prod_status;
         hold_slot_ff   <= prod_slot;
         hold_key_ff    <= prod_key;
         hold_value_ff  <= prod_value;
      end
      if (prod || op == OP_FINISH) begin
         rsp_kind_ff   <= hold_kind_ff;
         rsp_status_ff <= hold_status_ff;
         rsp_slot_ff   <= hold_slot_ff;
         rsp_key_ff    <= hold_key_ff;
         rsp_value_ff  <= hold_value_ff;
         rsp_last_ff   <= (op == OP_FINISH);
      end
   end

   assign status.go_drop    = go_drop;
   assign status.go_evict   = go_evict;
   assign status.evict_want = prune_ff || (usage_ff > USAGE_W'(capacity));
   assign status.scan_last  = (sel_ff == SLOT_W'(ENTRIES - 1));
   assign status.best_valid = best_valid_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = HANDLE_W'(rsp_slot_ff);
   assign rsp_out_key   = KEY_W'(rsp_key_ff);
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

   a_drop_has_ref: assert property (@(posedge clock) disable iff (reset)
      (op == OP_DROP) |-> (refc_ff[sel_ff] != '0))
      else $error("drop on slot with no reference");

   a_finish_has_result: assert property (@(posedge clock) disable iff (reset)
      (op == OP_FINISH) |-> hold_valid_ff)
      else $error("finish with no staged result");

   a_notice_slot_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_NOTICE) |-> !used_ff[rsp_slot_ff])
      else $error("notice for slot still in use");

endmodule

// ===== hw/rtl/lrucp_ctrl.sv =====
// controller state machine sequencing request handling and eviction
module lrucp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  lrucp_pkg::dp_status_type status,
   output lrucp_pkg::op_type        op,
   output logic                     busy
);
   import lrucp_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_DECIDE  = 7'b0000010,
      S_DROP    = 7'b0000100,
      S_EVCHK   = 7'b0001000,
      S_SCAN    = 7'b0010000,
      S_SCANEND = 7'b0100000,
      S_FINISH  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      evict_pend_ff, evict_pend_in;

   always_comb begin
      state_in      = state_ff;
      evict_pend_in = evict_pend_ff;
      op            = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op       = OP_LATCH;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            op            = OP_DECIDE;
            evict_pend_in = status.go_evict;
            if (status.go_drop) begin
               state_in = S_DROP;
            end else if (status.go_evict) begin
               state_in = S_EVCHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DROP: begin
            op       = OP_DROP;
            state_in = evict_pend_ff ? S_EVCHK : S_FINISH;
         end
         S_EVCHK: begin
            if (status.evict_want) begin
               op       = OP_SCAN_INIT;
               state_in = S_SCAN;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            op = OP_SCAN_STEP;
            if (status.scan_last) begin
               state_in = S_SCANEND;
            end
         end
         S_SCANEND: begin
            if (status.best_valid) begin
               op       = OP_TAKE_BEST;
               state_in = S_DROP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            op       = OP_FINISH;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         evict_pend_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         evict_pend_ff <= evict_pend_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== hw/rtl/lru_cache_with_pinned_entries_core.sv =====
// lru cache with reference-counted pinned entries: top level
// each request runs accept, decide and finish, plus a drop if needed and an evict check
// for an insert with a free slot or a prune; a check with usage over capacity, and every
// prune, scans all ENTRIES slots; each victim adds a drop and a rescan before the next notice
// the final result is valid in the first cycle with busy low; the receiver cannot stall
// reset clears all control state and capacity to zero
module lru_cache_with_pinned_entries_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lrucp_pkg::TYPE_W-1:0]        req_type,
   input  logic [lrucp_pkg::KEY_W-1:0]         req_key,
   input  logic [lrucp_pkg::HASH_W-1:0]        req_key_hash,
   input  logic [lrucp_pkg::VALUE_W-1:0]       req_value,
   input  logic [lrucp_pkg::CHARGE_W-1:0]      req_charge,
   input  logic [lrucp_pkg::HANDLE_W-1:0]      req_handle,
   output logic                                rsp_valid,
   output logic                                rsp_kind,
   output logic [lrucp_pkg::STATUS_W-1:0]      rsp_status,
   output logic [lrucp_pkg::HANDLE_W-1:0]      rsp_slot,
   output logic [lrucp_pkg::KEY_W-1:0]         rsp_out_key,
   output logic [lrucp_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic                                rsp_last,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lrucp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lrucp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lrucp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import lrucp_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   op_type           op;
   dp_status_type    status;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_CAPACITY) begin
         capacity_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_CAPACITY) ? CSR_DATA_W'(capacity_ff) : '0;

   lrucp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   lrucp_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .capacity      (capacity_ff),
      .req_type      (req_type),
      .req_key       (req_key),
      .req_key_hash  (req_key_hash),
      .req_value     (req_value),
      .req_charge    (req_charge),
      .req_handle    (req_handle),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

endmodule
